>>> src/wrs_pkg.sv
// Shared types and constants for the weighted random selector.
package wrs_pkg;

	// Number of weight registers held, whatever the number of live entries
	localparam int NUM_WEIGHTS = 8;
	localparam int WEIGHT_W    = 8;
	localparam int CFG_INDEX_W = $clog2(NUM_WEIGHTS);
	localparam int WORD_W      = 16;
	localparam int ENTRY_W     = 3;
	// Total of all weights at most NUM_WEIGHTS * 255 = 2040
	localparam int REM_W       = $clog2(NUM_WEIGHTS * ((1 << WEIGHT_W) - 1) + 1);
	localparam int ENTRIES_DEF = 8;

	// Reset weight of entry 0; all others reset to zero
	localparam logic [WEIGHT_W-1:0] WEIGHT0_RST = WEIGHT_W'(1);

	typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weight_array_t;

	// Beat handed along the modulo chain
	typedef struct packed {
		logic [WORD_W-1:0] word; // dividend bits still to be shifted in
		logic [REM_W-1:0]  rem;  // partial remainder
	} div_beat_t;

endpackage

>>> src/wrs_mod_cell.sv
// One restoring step of the modulo chain, with its own valid bit and stall handling.
module wrs_mod_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [wrs_pkg::REM_W-1:0] total,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  wrs_pkg::div_beat_t        up_beat,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output wrs_pkg::div_beat_t        dn_beat
);

	logic                        valid_q;
	wrs_pkg::div_beat_t          beat_q;
	logic [wrs_pkg::REM_W:0]     trial;
	logic [wrs_pkg::REM_W:0]     diff;
	wrs_pkg::div_beat_t          beat_next;

	// Shift in the next dividend bit and subtract the total where it fits
	always_comb begin
		trial = {up_beat.rem, up_beat.word[wrs_pkg::WORD_W-1]};
		diff  = trial - {1'b0, total};
		beat_next.word = {up_beat.word[wrs_pkg::WORD_W-2:0], 1'b0};
		if (trial >= {1'b0, total}) begin
			beat_next.rem = diff[wrs_pkg::REM_W-1:0];
		end else begin
			beat_next.rem = trial[wrs_pkg::REM_W-1:0];
		end
	end

	// Cell loads whenever it is empty or its beat moves on
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			beat_q <= beat_next;
		end
	end

	assign dn_valid = valid_q;
	assign dn_beat  = beat_q;

endmodule

>>> src/wrs_select.sv
// Prefix compare of the draw against the running weight sums, and the output register.
module wrs_select #(
	parameter int ENTRIES = wrs_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wrs_pkg::weight_array_t      weights,
	input  logic [wrs_pkg::REM_W-1:0]   total,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  wrs_pkg::div_beat_t          up_beat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wrs_pkg::ENTRY_W-1:0] chosen_entry,
	output logic                        zero_total
);

	logic                        valid_q;
	logic [wrs_pkg::ENTRY_W-1:0] chosen_q;
	logic                        zero_q;
	logic [wrs_pkg::ENTRY_W-1:0] pick;
	logic [wrs_pkg::REM_W-1:0]   running;
	logic                        found;

	// Lowest entry whose running sum exceeds the draw; entry 0 on a zero total
	always_comb begin
		running = '0;
		found   = 1'b0;
		pick    = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			running = running + wrs_pkg::REM_W'(weights[i]);
			if (!found && (up_beat.rem < running)) begin
				pick  = wrs_pkg::ENTRY_W'(i);
				found = 1'b1;
			end
		end
		if (total == '0) begin
			pick = '0;
		end
	end

	assign up_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			chosen_q <= pick;
			zero_q   <= (total == '0);
		end
	end

	assign out_valid    = valid_q;
	assign chosen_entry = chosen_q;
	assign zero_total   = zero_q;

endmodule

>>> src/weighted_random_select.sv
// Top level of the weighted random selector: weight registers, modulo chain and selection.
//
// Usage: write the eight 8-bit weights through cfg_we / cfg_index / cfg_data while
// the block is idle; only entries 0 .. ENTRIES-1 take part. Each beat on the input
// channel (in_valid / in_ready, random_word) yields one beat on the output channel
// (out_valid / out_ready, chosen_entry, zero_total), in order.
// The random word is reduced modulo the total weight by a row of 16 cells, one
// restoring subtract step per cell and one register per cell; a final stage
// compares the remainder against the running weight sums and registers the result.
// Path: an accepted beat passes the 16 cell registers and then the output register,
// the first of them loaded at the accepting edge.
// Throughput: one beat per cycle; every cell holds its own beat, so a new beat is
// taken whenever the first cell is empty or its beat moves on.
// When the receiver stalls, beats pile up in the chain and in_ready falls only once
// every cell and the output register are full (17 beats); nothing is dropped.
// An all-zero total gives chosen_entry 0 with zero_total set.
// Reset empties the chain and loads weight 1 into entry 0, 0 into the others.
module weighted_random_select #(
	parameter int ENTRIES = wrs_pkg::ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wrs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [wrs_pkg::WEIGHT_W-1:0]    cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [wrs_pkg::WORD_W-1:0]      random_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [wrs_pkg::ENTRY_W-1:0]     chosen_entry,
	output logic                            zero_total
);

	localparam int STEPS = wrs_pkg::WORD_W;

	wrs_pkg::weight_array_t    weight_q;
	logic [wrs_pkg::REM_W-1:0] total;

	logic               c_valid [STEPS+1];
	logic               c_ready [STEPS+1];
	wrs_pkg::div_beat_t c_beat  [STEPS+1];

	// Weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wrs_pkg::NUM_WEIGHTS; i++) begin
				weight_q[i] <= (i == 0) ? wrs_pkg::WEIGHT0_RST : '0;
			end
		end else if (cfg_we) begin
			weight_q[cfg_index] <= cfg_data;
		end
	end

	// Total of the live weights; the user must keep it steady while beats are in flight, the block does not enforce it
	always_comb begin
		total = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			total = total + wrs_pkg::REM_W'(weight_q[i]);
		end
	end

	// Input beat enters the chain with a cleared remainder
	assign c_valid[0]     = in_valid;
	assign c_beat[0].word = random_word;
	assign c_beat[0].rem  = '0;
	assign in_ready       = c_ready[0];

	// Modulo chain
	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		wrs_mod_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.total    (total),
			.up_valid (c_valid[k]),
			.up_ready (c_ready[k]),
			.up_beat  (c_beat[k]),
			.dn_valid (c_valid[k+1]),
			.dn_ready (c_ready[k+1]),
			.dn_beat  (c_beat[k+1])
		);
	end

	wrs_select #(
		.ENTRIES (ENTRIES)
	) u_select (
		.clk          (clk),
		.arst_n       (arst_n),
		.weights      (weight_q),
		.total        (total),
		.up_valid     (c_valid[STEPS]),
		.up_ready     (c_ready[STEPS]),
		.up_beat      (c_beat[STEPS]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.chosen_entry (chosen_entry),
		.zero_total   (zero_total)
	);

endmodule

>>> dv/tb_weighted_random_select.sv
`timescale 1ns / 100ps
// Self-checking testbench for the weighted random selector: directed and random draws.
module tb_weighted_random_select;

	localparam int LIVE_ENTRIES = wrs_pkg::ENTRIES_DEF;
	localparam int LATENCY      = 17;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RAND_PHASES  = 12;
	localparam int PHASE_WORDS  = 95;
	// Weight registers sit at indexes 0 .. NUM_WEIGHTS-1
	localparam int REG_WEIGHT_BASE = 0;

	// One predicted result beat
	typedef struct packed {
		logic [wrs_pkg::ENTRY_W-1:0] entry;
		logic                        zero;
	} selection_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_we      = 1'b0;
	logic [wrs_pkg::CFG_INDEX_W-1:0] cfg_index   = '0;
	logic [wrs_pkg::WEIGHT_W-1:0]    cfg_data    = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic [wrs_pkg::WORD_W-1:0]      random_word = '0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [wrs_pkg::ENTRY_W-1:0]     chosen_entry;
	logic                            zero_total;

	logic [wrs_pkg::WORD_W-1:0] pending_words[$];
	selection_t                 expected_picks[$];
	wrs_pkg::weight_array_t     weight_shadow;
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	int                         error_count   = 0;
	int                         cycle_count   = 0;

	weighted_random_select #(
		.ENTRIES(LIVE_ENTRIES)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.random_word (random_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.chosen_entry(chosen_entry),
		.zero_total  (zero_total)
	);

	always #5 clk = ~clk;

	// Sum of the live weights
	function automatic int unsigned live_total(wrs_pkg::weight_array_t w);
		int unsigned sum;
		sum = 0;
		for (int i = 0; i < LIVE_ENTRIES; i++)
			sum += w[i];
		return sum;
	endfunction

	// Roulette pick: first entry whose running weight sum exceeds word mod total
	function automatic selection_t predict_selection(logic [wrs_pkg::WORD_W-1:0] word,
			wrs_pkg::weight_array_t w);
		int unsigned total;
		int unsigned draw;
		int unsigned running;
		bit          found;
		selection_t  pick;
		total = live_total(w);
		pick  = '0;
		if (total == 0) begin
			pick.zero = 1'b1;
			return pick;
		end
		draw    = word % total;
		running = 0;
		found   = 1'b0;
		for (int i = 0; i < LIVE_ENTRIES; i++) begin
			running += w[i];
			if (!found && draw < running) begin
				pick.entry = wrs_pkg::ENTRY_W'(i);
				found      = 1'b1;
			end
		end
		return pick;
	endfunction

	// Random weight set: mostly mixed, now and then all zero or all full
	function automatic wrs_pkg::weight_array_t random_weights();
		wrs_pkg::weight_array_t w;
		int                     style;
		style = $urandom_range(11);
		for (int i = 0; i < wrs_pkg::NUM_WEIGHTS; i++) begin
			if (style == 0)
				w[i] = '0;
			else if (style == 1)
				w[i] = '1;
			else begin
				case ($urandom_range(3))
					0: w[i] = '0;
					1: w[i] = '1;
					2: w[i] = wrs_pkg::WEIGHT_W'($urandom_range(1, 8));
					default: w[i] = wrs_pkg::WEIGHT_W'($urandom);
				endcase
			end
		end
		return w;
	endfunction

	// Register writes, one per cycle; a partial write leaves the rest as they were
	task automatic program_weights(input wrs_pkg::weight_array_t w, input bit write_all);
		for (int i = 0; i < wrs_pkg::NUM_WEIGHTS; i++) begin
			if (write_all || $urandom_range(9) < 7) begin
				@(posedge clk);
				cfg_we    <= 1'b1;
				cfg_index <= wrs_pkg::CFG_INDEX_W'(REG_WEIGHT_BASE + i);
				cfg_data  <= w[i];
				weight_shadow[i] = w[i];
			end
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// Nothing queued, nothing offered, nothing outstanding
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || in_valid || expected_picks.size() != 0);
	endtask

	// Input driver: holds a beat until taken, idles at random between beats
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				expected_picks.push_back(predict_selection(random_word, weight_shadow));
			if (!in_valid || in_ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					random_word <= pending_words.pop_front();
					in_valid    <= 1'b1;
				end else begin
					random_word <= wrs_pkg::WORD_W'($urandom);
					in_valid    <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result beat against the oldest prediction
	always @(posedge clk) begin
		selection_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_picks.size() == 0) begin
					$error("unexpected result beat: chosen_entry %0d zero_total %0b",
						chosen_entry, zero_total);
					error_count++;
				end else begin
					want = expected_picks.pop_front();
					if (chosen_entry !== want.entry) begin
						$error("chosen_entry: expected %0d, actual %0d", want.entry, chosen_entry);
						error_count++;
					end
					if (zero_total !== want.zero) begin
						$error("zero_total: expected %0b, actual %0b", want.zero, zero_total);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_weighted_random_select: done, errors");
			$finish;
		end
	end

	// Stimulus sequence
	initial begin
		wrs_pkg::weight_array_t w;
		int unsigned            total;
		int unsigned            near;
		weight_shadow    = '0;
		weight_shadow[0] = wrs_pkg::WEIGHT0_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		set_idling(25, 58);

		// Reset weights: only entry 0 live
		@(negedge clk);
		pending_words.push_back(16'h0000);
		pending_words.push_back(16'hFFFF);
		pending_words.push_back(16'h0001);
		wait_drained();

		// All weights zero: entry 0 with the zero flag
		program_weights('0, 1'b1);
		@(negedge clk);
		pending_words.push_back(16'h0000);
		pending_words.push_back(16'hFFFF);
		pending_words.push_back(16'h5A5A);
		wait_drained();

		// All weights full: total 2040, wrap points
		program_weights('1, 1'b1);
		@(negedge clk);
		pending_words.push_back(16'd0);
		pending_words.push_back(16'd254);
		pending_words.push_back(16'd255);
		pending_words.push_back(16'd2039);
		pending_words.push_back(16'd2040);
		pending_words.push_back(16'hFFFF);
		wait_drained();

		// Only the last entry live
		w    = '0;
		w[7] = 8'd1;
		program_weights(w, 1'b1);
		@(negedge clk);
		pending_words.push_back(16'h0000);
		pending_words.push_back(16'hFFFF);
		wait_drained();

		// Sparse weights with zero entries in between, total 10
		w    = '0;
		w[1] = 8'd3;
		w[4] = 8'd5;
		w[7] = 8'd2;
		program_weights(w, 1'b1);
		@(negedge clk);
		pending_words.push_back(16'd0);
		pending_words.push_back(16'd2);
		pending_words.push_back(16'd3);
		pending_words.push_back(16'd7);
		pending_words.push_back(16'd8);
		pending_words.push_back(16'd9);
		pending_words.push_back(16'd10);
		pending_words.push_back(16'hFFFF);
		wait_drained();

		// Random phases, idling pattern changes every third of the run
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p / (RAND_PHASES / 3))
				0: set_idling(25, 58);
				1: set_idling(58, 25);
				default: set_idling(0, 0);
			endcase
			program_weights(random_weights(), p == 0);
			total = live_total(weight_shadow);
			@(negedge clk);
			for (int k = 0; k < PHASE_WORDS; k++) begin
				case ($urandom_range(19))
					0, 1, 2: begin
						// land on or just below a wrap of the modulo
						if (total == 0) begin
							near = $urandom;
						end else begin
							near = $urandom_range(65535 / total) * total;
							if ($urandom_range(1))
								near = near + total - 1;
						end
						pending_words.push_back(wrs_pkg::WORD_W'(near));
					end
					3: pending_words.push_back(16'h0000);
					4: pending_words.push_back(16'hFFFF);
					5: pending_words.push_back(wrs_pkg::WORD_W'($urandom_range(15)));
					default: pending_words.push_back(wrs_pkg::WORD_W'($urandom));
				endcase
			end
			wait_drained();
		end

		// Let any stray beat come out
		repeat (LATENCY + 5) @(posedge clk);
		if (expected_picks.size() != 0) begin
			$error("%0d result beats never arrived", expected_picks.size());
			error_count++;
		end
		if (error_count == 0)
			$display("tb_weighted_random_select: done, clean");
		else
			$display("tb_weighted_random_select: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
src/wrs_pkg.sv
src/wrs_mod_cell.sv
src/wrs_select.sv
src/weighted_random_select.sv
dv/tb_weighted_random_select.sv
